// ===== rtl/rgbh_pkg.sv =====
// ----------------------------------------------------------------------------
// rgbh_pkg
// Shared types and constants of the RGB channel histogram.
// ----------------------------------------------------------------------------
package rgbh_pkg;

    localparam int unsigned NUM_CHAN  = 3;
    localparam int unsigned CHAN_BITS = 8;
    localparam int unsigned OUT_BITS  = 24;

    // Request modes
    localparam logic MODE_ACCUM = 1'b0;
    localparam logic MODE_READ  = 1'b1;

    typedef struct packed {
        logic                 mode;
        logic [CHAN_BITS-1:0] red;
        logic [CHAN_BITS-1:0] green;
        logic [CHAN_BITS-1:0] blue;
        logic [CHAN_BITS-1:0] bin_index;
    } rgbh_in_t;

    typedef struct packed {
        logic [OUT_BITS-1:0] red_count;
        logic [OUT_BITS-1:0] green_count;
        logic [OUT_BITS-1:0] blue_count;
        logic                bad_bin;
    } rgbh_out_t;

    // Per-bank control from the top level
    typedef struct packed {
        logic rd_en;   // read the bin at rd_addr
        logic inc_en;  // bump the entry read last cycle
        logic clr_en;  // write zero at clr_addr
    } rgbh_bank_ctrl_t;

    typedef enum logic {
        ST_CLEAR,
        ST_RUN
    } rgbh_state_t;

endpackage

// ===== rtl/rgb_channel_histogram_top.sv =====
// ----------------------------------------------------------------------------
// rgb_channel_histogram_top
// Red, green and blue histograms of a pixel stream with bin read-back.
// ----------------------------------------------------------------------------
//
//  channel  | ports                          | moves
//  ---------+--------------------------------+------------------------------
//  input    | s_valid s_ready s_data         | pixel or bin read request
//  result   | m_valid m_ready m_data         | three counts and bad_bin
//  config   | cfg_wr_en cfg_wr_data          | max_level, no wait
//
//  One request per cycle is taken, pixel or read, while s_ready is high; a
//  read result goes through stage 1 and the output register. Each channel's
//  bins sit in a single-port-write RAM, read on accept and written in the
//  cycle after. After reset a clearing pass zeroes the bins one by one,
//  with s_ready low. A read whose result cannot leave (m_valid high, m_ready
//  low) holds the pipeline stage and drops s_ready until the output frees.
//
module rgb_channel_histogram_top
    import rgbh_pkg::*;
#(
    parameter int unsigned NUM_BINS   = 256,
    parameter int unsigned COUNT_BITS = 24
) (
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 cfg_wr_en,
    input  logic [CHAN_BITS-1:0] cfg_wr_data,

    input  logic                 s_valid,
    output logic                 s_ready,
    input  rgbh_in_t             s_data,

    output logic                 m_valid,
    input  logic                 m_ready,
    output rgbh_out_t            m_data
);

    localparam int unsigned AW       = $clog2(NUM_BINS);
    localparam int unsigned LAST_BIN = NUM_BINS - 1;

    // Control state
    rgbh_state_t          state_reg, state_next;
    logic [AW-1:0]        clr_cnt_reg, clr_cnt_next;
    logic [CHAN_BITS-1:0] max_level_reg;

    // Stage 1: request whose RAM data is now available
    logic                 p1_valid_reg, p1_valid_next;
    logic                 p1_mode_reg;
    logic                 p1_bad_reg;
    logic [NUM_CHAN-1:0]  p1_en_reg;

    logic                 out_valid_reg, out_valid_next;
    rgbh_out_t            out_data_reg;

    logic                 clearing;
    logic                 accept;
    logic                 p1_stall;
    logic                 out_load;
    logic                 rd_bad;

    logic [CHAN_BITS-1:0]  chan_val   [NUM_CHAN];
    logic [NUM_CHAN-1:0]   chan_en;
    logic [COUNT_BITS-1:0] bank_count [NUM_CHAN];

    // ------------------------------------------------------------------
    // Range checks against min(max_level, NUM_BINS - 1)
    // ------------------------------------------------------------------
    assign chan_val[0] = s_data.red;
    assign chan_val[1] = s_data.green;
    assign chan_val[2] = s_data.blue;

    always_comb begin
        for (int i = 0; i < NUM_CHAN; i++) begin
            chan_en[i] = (chan_val[i] <= max_level_reg) &&
                         (32'(chan_val[i]) <= 32'(LAST_BIN));
        end
    end

    assign rd_bad = (s_data.bin_index > max_level_reg) ||
                    (32'(s_data.bin_index) > 32'(LAST_BIN));

    // ------------------------------------------------------------------
    // Handshake
    // ------------------------------------------------------------------
    // Only a read request can stall stage 1; a pixel never waits for the output.
    assign p1_stall = p1_valid_reg && (p1_mode_reg == MODE_READ) &&
                      out_valid_reg && !m_ready;
    assign s_ready  = !clearing && !p1_stall;
    assign accept   = s_valid && s_ready;
    assign out_load = p1_valid_reg && (p1_mode_reg == MODE_READ) && !p1_stall;

    assign p1_valid_next  = accept || p1_stall;
    assign out_valid_next = out_load || (out_valid_reg && !m_ready);

    // ------------------------------------------------------------------
    // Clearing sequencer
    // ------------------------------------------------------------------
    always_comb begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == AW'(LAST_BIN)) begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                state_next = ST_RUN;
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_comb begin
        unique case (state_reg)
            ST_CLEAR: clearing = 1'b1;
            ST_RUN:   clearing = 1'b0;
            default:  clearing = 1'b1;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            max_level_reg <= '1;
            p1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            p1_valid_reg  <= p1_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en) begin
                max_level_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            p1_mode_reg <= s_data.mode;
            p1_bad_reg  <= rd_bad;
            p1_en_reg   <= chan_en;
        end
        if (out_load) begin
            out_data_reg.bad_bin     <= p1_bad_reg;
            out_data_reg.red_count   <= p1_bad_reg ? '0 : OUT_BITS'(bank_count[0]);
            out_data_reg.green_count <= p1_bad_reg ? '0 : OUT_BITS'(bank_count[1]);
            out_data_reg.blue_count  <= p1_bad_reg ? '0 : OUT_BITS'(bank_count[2]);
        end
    end

    // ------------------------------------------------------------------
    // Bin memories, one per channel
    // ------------------------------------------------------------------
    for (genvar g = 0; g < NUM_CHAN; g++) begin : g_bank
        rgbh_bank_ctrl_t bank_ctrl;
        logic [AW-1:0]   bank_addr;

        assign bank_addr = (s_data.mode == MODE_READ) ? AW'(s_data.bin_index)
                                                      : AW'(chan_val[g]);

        assign bank_ctrl.rd_en  = accept;
        assign bank_ctrl.inc_en = p1_valid_reg && (p1_mode_reg == MODE_ACCUM) &&
                                  p1_en_reg[g];
        assign bank_ctrl.clr_en = clearing;

        rgbh_bank #(
            .NUM_BINS   (NUM_BINS),
            .COUNT_BITS (COUNT_BITS)
        ) u_bank (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .ctrl     (bank_ctrl),
            .rd_addr  (bank_addr),
            .clr_addr (clr_cnt_reg),
            .count    (bank_count[g])
        );
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_no_accept_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        clearing |-> !s_ready)
        else $error("request accepted during clearing pass");

    a_stage_empty_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        clearing |-> !p1_valid_reg)
        else $error("bin update overlaps clearing pass");

    a_read_held: assert property (@(posedge aclk) disable iff (!aresetn)
        p1_stall |=> p1_valid_reg && (p1_mode_reg == MODE_READ) && $stable(p1_bad_reg))
        else $error("stalled read lost from stage 1");

    a_bad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.bad_bin) |->
            (m_data.red_count == '0) && (m_data.green_count == '0) &&
            (m_data.blue_count == '0))
        else $error("bad bin result carries nonzero counts");

endmodule

// ===== rtl/rgbh_bank.sv =====
// ----------------------------------------------------------------------------
// rgbh_bank
// One channel's bin memory with saturating read-modify-write and forwarding.
// ----------------------------------------------------------------------------
module rgbh_bank
    import rgbh_pkg::*;
#(
    parameter int unsigned NUM_BINS   = 256,
    parameter int unsigned COUNT_BITS = 24
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  rgbh_bank_ctrl_t               ctrl,
    input  logic [$clog2(NUM_BINS)-1:0]   rd_addr,
    input  logic [$clog2(NUM_BINS)-1:0]   clr_addr,
    output logic [COUNT_BITS-1:0]         count
);

    localparam int unsigned AW = $clog2(NUM_BINS);

    logic [COUNT_BITS-1:0] mem [NUM_BINS];

    logic [COUNT_BITS-1:0] rd_data_reg;
    logic [AW-1:0]         addr_reg;
    logic                  fwd_valid_reg;
    logic [AW-1:0]         fwd_addr_reg;
    logic [COUNT_BITS-1:0] fwd_data_reg;

    logic                  wr_en;
    logic [AW-1:0]         wr_addr;
    logic [COUNT_BITS-1:0] wr_data;
    logic [COUNT_BITS-1:0] inc_val;

    // Write landing on the same edge as the read is not seen by the RAM.
    assign count = (fwd_valid_reg && (fwd_addr_reg == addr_reg)) ? fwd_data_reg
                                                                  : rd_data_reg;

    // Saturate at all ones
    assign inc_val = (&count) ? count : count + 1'b1;

    assign wr_en   = ctrl.clr_en | ctrl.inc_en;
    assign wr_addr = ctrl.clr_en ? clr_addr : addr_reg;
    assign wr_data = ctrl.clr_en ? '0 : inc_val;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (ctrl.rd_en) begin
            rd_data_reg <= mem[rd_addr];
            addr_reg    <= rd_addr;
        end
    end

    // Forward info describes the write coinciding with the latest read.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_valid_reg <= 1'b0;
        end else if (ctrl.rd_en) begin
            fwd_valid_reg <= wr_en;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.rd_en) begin
            fwd_addr_reg <= wr_addr;
            fwd_data_reg <= wr_data;
        end
    end

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for rgb_channel_histogram_top. A queue of pixel and
// bin-read requests feeds a valid/ready driver. A monitor compares every
// read result with counts kept by a cycle-free histogram predictor.
// ----------------------------------------------------------------------------
module testbench;
    import rgbh_pkg::*;

    localparam int unsigned     HIST_BINS = 256;
    localparam logic [OUT_BITS-1:0] COUNT_MAX = '1;
    localparam int unsigned     IDLE_PCT  = 31;

    logic      aclk        = 1'b0;
    logic      aresetn     = 1'b0;
    logic      cfg_wr_en   = 1'b0;
    logic [CHAN_BITS-1:0] cfg_wr_data = '0;
    logic      s_valid     = 1'b0;
    logic      s_ready;
    rgbh_in_t  s_data      = '0;
    logic      m_valid;
    logic      m_ready     = 1'b0;
    rgbh_out_t m_data;

    // Requests waiting for the driver, and read results still owed by the block
    rgbh_in_t  pixel_q[$];
    rgbh_out_t bin_counts_q[$];

    // Predicted histograms and the max_level the block currently holds
    logic [OUT_BITS-1:0]  red_hist   [HIST_BINS];
    logic [OUT_BITS-1:0]  green_hist [HIST_BINS];
    logic [OUT_BITS-1:0]  blue_hist  [HIST_BINS];
    logic [CHAN_BITS-1:0] max_level_cfg = 8'd255;

    int unsigned issued_cnt   = 0;
    int unsigned accepted_cnt = 0;
    int unsigned mismatch_cnt = 0;
    bit          no_idle      = 1'b0;   // both sides run flat out while set

    rgb_channel_histogram_top dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

    always #4 aclk = ~aclk;

    // ------------------------------------------------------------------------
    // Predictor: one accepted request updates the bins or yields one read.
    // A channel value above max_level is skipped; counts stop at all ones.
    // ------------------------------------------------------------------------
    task automatic histogram_update(input rgbh_in_t req);
        rgbh_out_t res;
        if (req.mode == MODE_ACCUM) begin
            if (req.red <= max_level_cfg && red_hist[req.red] != COUNT_MAX)
                red_hist[req.red] = red_hist[req.red] + 1'b1;
            if (req.green <= max_level_cfg && green_hist[req.green] != COUNT_MAX)
                green_hist[req.green] = green_hist[req.green] + 1'b1;
            if (req.blue <= max_level_cfg && blue_hist[req.blue] != COUNT_MAX)
                blue_hist[req.blue] = blue_hist[req.blue] + 1'b1;
        end else begin
            res = '0;
            if (req.bin_index > max_level_cfg) begin
                // out-of-range bin: flag set, counts forced to zero
                res.bad_bin = 1'b1;
            end else begin
                res.red_count   = red_hist[req.bin_index];
                res.green_count = green_hist[req.bin_index];
                res.blue_count  = blue_hist[req.bin_index];
            end
            bin_counts_q.push_back(res);
        end
    endtask

    task automatic flag_mismatch(input string what, input logic [OUT_BITS-1:0] got,
                                 input logic [OUT_BITS-1:0] want);
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        mismatch_cnt++;
    endtask

    // ------------------------------------------------------------------------
    // Driver: holds valid and payload until accepted, then takes the next
    // request from the queue unless it decides to idle this cycle.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                histogram_update(s_data);
                accepted_cnt++;
            end
            if (!s_valid || s_ready) begin
                if (pixel_q.size() != 0 &&
                    (no_idle || $urandom_range(0, 99) >= IDLE_PCT)) begin
                    s_valid <= 1'b1;
                    s_data  <= pixel_q.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: random back-pressure; each taken result is checked against
    // the oldest predicted read.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin : result_monitor
        rgbh_out_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (bin_counts_q.size() == 0) begin
                    flag_mismatch("result with no read pending", '0, '0);
                end else begin
                    want = bin_counts_q.pop_front();
                    if (m_data.red_count !== want.red_count)
                        flag_mismatch("red_count", m_data.red_count, want.red_count);
                    if (m_data.green_count !== want.green_count)
                        flag_mismatch("green_count", m_data.green_count, want.green_count);
                    if (m_data.blue_count !== want.blue_count)
                        flag_mismatch("blue_count", m_data.blue_count, want.blue_count);
                    if (m_data.bad_bin !== want.bad_bin)
                        flag_mismatch("bad_bin", OUT_BITS'(m_data.bad_bin),
                                      OUT_BITS'(want.bad_bin));
                end
            end
            m_ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // ------------------------------------------------------------------------
    // Request builders and helpers for the sequence below
    // ------------------------------------------------------------------------
    task automatic push_pixel(input int r, input int g, input int b);
        rgbh_in_t req;
        req           = '0;
        req.mode      = MODE_ACCUM;
        req.red       = r[7:0];
        req.green     = g[7:0];
        req.blue      = b[7:0];
        req.bin_index = 8'($urandom_range(0, 255));   // ignored in accumulate mode
        pixel_q.push_back(req);
        issued_cnt++;
    endtask

    task automatic push_read(input int bin);
        rgbh_in_t req;
        req           = '0;
        req.mode      = MODE_READ;
        req.red       = 8'($urandom_range(0, 255));   // ignored in read mode
        req.green     = 8'($urandom_range(0, 255));
        req.blue      = 8'($urandom_range(0, 255));
        req.bin_index = bin[7:0];
        pixel_q.push_back(req);
        issued_cnt++;
    endtask

    // Skewed toward a few hot bins so counts build up, and toward the
    // max_level boundary where the in/out-of-range split happens.
    function automatic int pick_level();
        int v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: v = $urandom_range(0, 7);
            4, 5:       v = int'(max_level_cfg) + int'($urandom_range(0, 2)) - 1;
            default:    v = $urandom_range(0, 255);
        endcase
        if (v < 0)   v = 0;
        if (v > 255) v = 255;
        return v;
    endfunction

    // Everything issued is accepted and every read has come back; the extra
    // cycles let a trailing pixel finish its bin write.
    task automatic wait_idle();
        while (accepted_cnt != issued_cnt || bin_counts_q.size() != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_max_level(input int lvl);
        wait_idle();
        @(posedge aclk);
        cfg_wr_en     <= 1'b1;
        cfg_wr_data   <= lvl[7:0];
        max_level_cfg  = lvl[7:0];
        @(posedge aclk);
        cfg_wr_en     <= 1'b0;
    endtask

    task automatic random_phase(input int lvl, input int n_req);
        write_max_level(lvl);
        repeat (n_req) begin
            if ($urandom_range(0, 99) < 60)
                push_pixel(pick_level(), pick_level(), pick_level());
            else
                push_read(pick_level());
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        for (int i = 0; i < HIST_BINS; i++) begin
            red_hist[i]   = '0;
            green_hist[i] = '0;
            blue_hist[i]  = '0;
        end
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // Full range: empty reads, extreme pixels, then read them back
        write_max_level(255);
        push_read(0);
        push_read(255);
        push_pixel(0, 0, 0);
        push_pixel(255, 255, 255);
        push_pixel(0, 255, 128);
        push_pixel(170, 85, 1);
        push_read(0);
        push_read(255);
        push_read(128);
        push_read(85);
        push_read(1);
        push_read(170);

        // Limit of one: values above 1 dropped per channel only
        write_max_level(1);
        push_pixel(1, 0, 2);
        push_pixel(2, 1, 1);
        push_pixel(0, 255, 1);
        push_read(0);
        push_read(1);
        push_read(2);
        push_read(255);

        // Register at zero: only bin 0 valid
        write_max_level(0);
        push_pixel(0, 1, 0);
        push_pixel(3, 0, 0);
        push_read(0);
        push_read(1);

        // Random phases over several limits; one runs with no idling at all
        random_phase(255, 180);
        wait_idle();
        no_idle = 1'b1;
        random_phase($urandom_range(2, 254), 180);
        wait_idle();
        no_idle = 1'b0;
        random_phase(1, 180);
        random_phase(0, 180);
        random_phase($urandom_range(2, 254), 180);
        random_phase(255, 180);

        wait_idle();
        if (mismatch_cnt == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run
    initial begin
        #5_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
